/* design/qty_pkg.sv */
// Package with shared widths, constants, the CORDIC stage word and the arctangent table.
`timescale 1ns / 1ps
package qty_pkg;

    // Requested CORDIC stage count and the number of stages actually built.
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int NSTG          = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    // Widths.
    localparam int QW    = 16;  // quaternion component, Q2.14
    localparam int PW    = 32;  // product of two components, Q4.28
    localparam int T3W   = 34;  // sine part 2(wz + xy)
    localparam int T4W   = 35;  // cosine part 1 - 2(y^2 + z^2)
    localparam int XW    = 38;  // CORDIC x and y paths, with headroom for gain
    localparam int AW    = 35;  // angle accumulator, 2^-30 rad per unit
    localparam int YW    = 16;  // yaw output, Q3.13
    localparam int IDX_W = 5;   // stage index

    localparam logic signed [AW-1:0]  ANGLE_PI  = 35'sd3373259426;
    localparam logic signed [T4W-1:0] ONE_Q28   = 35'sd268435456;
    localparam logic signed [AW-1:0]  YAW_LIMIT = 35'sd25736;
    localparam logic signed [AW-1:0]  ROUND_ADD = 35'sd65536;
    localparam int                    OUT_SHIFT = 17;

    // Word handed from one CORDIC cell to the next.
    typedef struct packed {
        logic                 zero;  // both input parts were zero
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] acc;
    } cordic_t;

    // atan(2^-i) scaled by 2^30, rounded to nearest.
    function automatic logic signed [AW-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:    v = 35'sd843314857;
            5'd1:    v = 35'sd497837829;
            5'd2:    v = 35'sd263043837;
            5'd3:    v = 35'sd133525159;
            5'd4:    v = 35'sd67021687;
            5'd5:    v = 35'sd33543516;
            5'd6:    v = 35'sd16775851;
            5'd7:    v = 35'sd8388437;
            5'd8:    v = 35'sd4194283;
            5'd9:    v = 35'sd2097149;
            5'd10:   v = 35'sd1048576;
            5'd11:   v = 35'sd524288;
            5'd12:   v = 35'sd262144;
            5'd13:   v = 35'sd131072;
            5'd14:   v = 35'sd65536;
            5'd15:   v = 35'sd32768;
            5'd16:   v = 35'sd16384;
            5'd17:   v = 35'sd8192;
            5'd18:   v = 35'sd4096;
            5'd19:   v = 35'sd2048;
            5'd20:   v = 35'sd1024;
            5'd21:   v = 35'sd512;
            5'd22:   v = 35'sd256;
            5'd23:   v = 35'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/qty_front.sv */
// Front end: quaternion products, sine and cosine parts, and the half-plane pre-rotation.
`timescale 1ns / 1ps
module qty_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [15:0]      quat_x,
    input  logic signed [15:0]      quat_y,
    input  logic signed [15:0]      quat_z,
    input  logic signed [15:0]      quat_w,
    output logic                    out_valid,
    input  logic                    out_ready,
    output qty_pkg::cordic_t        out_data
);

    // Stage 1: four products.
    logic                                p_valid_reg;
    logic signed [qty_pkg::PW-1:0]       wz_reg, xy_reg, yy_reg, zz_reg;
    logic signed [qty_pkg::PW-1:0]       wz_next, xy_next, yy_next, zz_next;
    logic                                p_ready;

    // Stage 2: sine and cosine parts.
    logic                                t_valid_reg;
    logic signed [qty_pkg::T3W-1:0]      t3_reg, t3_next;
    logic signed [qty_pkg::T4W-1:0]      t4_reg, t4_next;
    logic                                t_ready;

    // Stage 3: CORDIC start word.
    logic                                r_valid_reg;
    qty_pkg::cordic_t                    r_data_reg, r_data_next;
    logic                                r_ready;

    assign r_ready  = !r_valid_reg || out_ready;
    assign t_ready  = !t_valid_reg || r_ready;
    assign p_ready  = !p_valid_reg || t_ready;
    assign in_ready = p_ready;

    always_comb begin
        wz_next = quat_w * quat_z;
        xy_next = quat_x * quat_y;
        yy_next = quat_y * quat_y;
        zz_next = quat_z * quat_z;
    end

    always_comb begin
        t3_next = (qty_pkg::T3W'(wz_reg) + qty_pkg::T3W'(xy_reg)) <<< 1;
        t4_next = qty_pkg::ONE_Q28
                - ((qty_pkg::T4W'(yy_reg) + qty_pkg::T4W'(zz_reg)) <<< 1);
    end

    // A negative cosine part puts the vector in the left half plane; turn it by pi first.
    always_comb begin
        r_data_next.zero = (t3_reg == '0) && (t4_reg == '0);
        r_data_next.x    = qty_pkg::XW'(t4_reg);
        r_data_next.y    = qty_pkg::XW'(t3_reg);
        r_data_next.acc  = '0;
        if (t4_reg < 0) begin
            r_data_next.x   = -qty_pkg::XW'(t4_reg);
            r_data_next.y   = -qty_pkg::XW'(t3_reg);
            r_data_next.acc = (t3_reg >= 0) ? qty_pkg::ANGLE_PI : -qty_pkg::ANGLE_PI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                p_valid_reg <= in_valid;
            end
            if (t_ready) begin
                t_valid_reg <= p_valid_reg;
            end
            if (r_ready) begin
                r_valid_reg <= t_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && in_valid) begin
            wz_reg <= wz_next;
            xy_reg <= xy_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
        end
        if (t_ready && p_valid_reg) begin
            t3_reg <= t3_next;
            t4_reg <= t4_next;
        end
        if (r_ready && t_valid_reg) begin
            r_data_reg <= r_data_next;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_data  = r_data_reg;

endmodule

/* design/qty_cell.sv */
// One vectoring CORDIC cell: a single micro-rotation with its own output register.
`timescale 1ns / 1ps
module qty_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [qty_pkg::IDX_W-1:0]     stage_idx,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  qty_pkg::cordic_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output qty_pkg::cordic_t              out_data
);

    logic                          valid_reg;
    qty_pkg::cordic_t              data_reg, data_next;
    logic signed [qty_pkg::XW-1:0] dx, dy;
    logic signed [qty_pkg::AW-1:0] step_angle;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
        dx         = in_data.y >>> stage_idx;
        dy         = in_data.x >>> stage_idx;
        step_angle = qty_pkg::atan_q30(stage_idx);
        data_next  = in_data;
        if (in_data.y >= 0) begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + step_angle;
        end else begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - step_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/qty_out.sv */
// Output stage: rounds the angle to Q3.13, clamps it to plus or minus pi and holds the result.
`timescale 1ns / 1ps
module qty_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  qty_pkg::cordic_t              in_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_yaw_angle
);

    logic                          valid_reg;
    logic signed [15:0]            yaw_reg, yaw_next;
    logic signed [qty_pkg::AW-1:0] rounded;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        rounded = (in_data.acc + qty_pkg::ROUND_ADD) >>> qty_pkg::OUT_SHIFT;
        if (in_data.zero) begin
            yaw_next = '0;
        end else if (rounded > qty_pkg::YAW_LIMIT) begin
            yaw_next = qty_pkg::YW'(qty_pkg::YAW_LIMIT);
        end else if (rounded < -qty_pkg::YAW_LIMIT) begin
            yaw_next = -qty_pkg::YW'(qty_pkg::YAW_LIMIT);
        end else begin
            yaw_next = qty_pkg::YW'(rounded);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            yaw_reg <= yaw_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_yaw_angle = yaw_reg;

endmodule

/* design/quaternion_to_yaw.sv */
// Top level: quaternion to yaw heading through a pipelined chain of CORDIC cells.
//
//   Channel   Direction  Ports                                   Transfer when
//   s_        in         s_quat_x, s_quat_y, s_quat_z, s_quat_w   s_valid && s_ready
//   m_        out        m_yaw_angle                             m_valid && m_ready
//
// Every transfer on the input channel produces exactly one transfer on the output channel.
// Three front stages form the products, the sine and cosine parts and the pre-rotation,
// one cell per CORDIC stage follows, and the output register does rounding and clamping.
// A new quaternion is accepted every cycle while s_ready is high; each stage holds its own valid bit, so bubbles
// close up and the chain keeps filling while a finished result waits on m_ready.
// Reset is synchronous and active low and clears only the valid bits of the stages.
`timescale 1ns / 1ps
module quaternion_to_yaw (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_yaw_angle
);

    // Link g carries the word entering cell g; link NSTG feeds the output stage.
    qty_pkg::cordic_t link_data  [qty_pkg::NSTG+1];
    logic             link_valid [qty_pkg::NSTG+1];
    logic             link_ready [qty_pkg::NSTG+1];

    qty_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .quat_x    (s_quat_x),
        .quat_y    (s_quat_y),
        .quat_z    (s_quat_z),
        .quat_w    (s_quat_w),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // The chain of micro-rotation cells; each cell shifts by its own fixed stage index.
    for (genvar g = 0; g < qty_pkg::NSTG; g++) begin : g_cell
        qty_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (qty_pkg::IDX_W'(g)),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_data   (link_data[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_data  (link_data[g+1])
        );
    end

    qty_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (link_valid[qty_pkg::NSTG]),
        .in_ready    (link_ready[qty_pkg::NSTG]),
        .in_data     (link_data[qty_pkg::NSTG]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_yaw_angle (m_yaw_angle)
    );

    // The heading never leaves the range from minus pi to plus pi.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_yaw_angle <= 16'sd25736) && (m_yaw_angle >= -16'sd25736))
        else $error("yaw result outside plus or minus pi");

    // The input side only stalls when every stage is full and the output is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while the pipeline has room");

    // After a reset cycle no result is offered.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // Output stall: a valid result that is not taken must stay valid and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_yaw_angle))
        else $error("held result changed under stall");

endmodule

/* verif/quaternion_to_yaw_tb.sv */
// Self-checking testbench for the quaternion to yaw heading block.
`timescale 1ns / 1ps
module quaternion_to_yaw_tb;

    // The block keeps no state between quaternions, so every quaternion maps to one
    // heading on its own. The testbench predicts that heading when the input
    // transfer happens and compares it with the output transfers in order.

    localparam int STAGES_RUN  = (qty_pkg::CORDIC_STAGES > 24) ? 24 : qty_pkg::CORDIC_STAGES;
    // Pipeline depth is the front stages plus one cell per stage and the output stage.
    localparam int DRAIN       = 2 * (STAGES_RUN + 4) + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 500;
    localparam int N_RANDOM    = 1350;

    localparam longint ONE_Q28 = 64'sd268435456;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint YAW_MAX = 64'sd25736;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    typedef struct {
        quat_t              q;
        logic signed [15:0] yaw;
    } heading_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_quat_x    = '0;
    logic signed [15:0] s_quat_y    = '0;
    logic signed [15:0] s_quat_z    = '0;
    logic signed [15:0] s_quat_w    = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [15:0] m_yaw_angle;

    // Arctangent of 2^-i in units of 2^-30 rad, rounded to nearest.
    longint atan_steps [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    quat_t    quat_queue [$];      // quaternions still to be offered
    heading_t heading_queue [$];   // predicted headings not yet seen at the output
    quat_t    next_quat;

    int n_total    = 0;
    int n_offered  = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int send_gap   = 0;
    int recv_gap   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int cycles     = 0;

    quaternion_to_yaw uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_quat_x    (s_quat_x),
        .s_quat_y    (s_quat_y),
        .s_quat_z    (s_quat_z),
        .s_quat_w    (s_quat_w),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_yaw_angle (m_yaw_angle)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Synchronous active-low reset, held at the start and released once.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Heading prediction. The sine part 2(wz + xy) and the cosine part
    // 1 - 2(y^2 + z^2) are exact in Q4.28. A vectoring CORDIC then drives the
    // sine part to zero; a vector in the left half plane is first turned by pi,
    // starting the angle at +pi for a sine part of zero or more and at -pi
    // otherwise. Shifts are arithmetic, so they round toward minus infinity.
    function automatic logic signed [15:0] heading_of(input quat_t q);
        longint sin_part;
        longint cos_part;
        longint vx;
        longint vy;
        longint dx;
        longint dy;
        longint ang;
        longint q13;
        sin_part = 2 * (longint'(q.w) * longint'(q.z) + longint'(q.x) * longint'(q.y));
        cos_part = ONE_Q28 - 2 * (longint'(q.y) * longint'(q.y) + longint'(q.z) * longint'(q.z));
        vx  = cos_part;
        vy  = sin_part;
        ang = 0;
        if (vx == 0 && vy == 0) begin
            return '0;
        end
        if (vx < 0) begin
            ang = (vy >= 0) ? PI_Q30 : -PI_Q30;
            vx  = -vx;
            vy  = -vy;
        end
        for (int i = 0; i < STAGES_RUN; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + atan_steps[i];
            end else begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - atan_steps[i];
            end
        end
        // From 2^-30 to 2^-13 rad, rounding halves upward, then clamp to +-pi.
        q13 = (ang + 64'sd65536) >>> 17;
        if (q13 > YAW_MAX) q13 = YAW_MAX;
        if (q13 < -YAW_MAX) q13 = -YAW_MAX;
        return 16'(q13);
    endfunction

    // Mostly back to back, often a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_quat(input int x, input int y, input int z, input int w);
        quat_t q;
        q.x = 16'(x);
        q.y = 16'(y);
        q.z = 16'(z);
        q.w = 16'(w);
        quat_queue.push_back(q);
    endtask

    // A normalized quaternion in random direction, scaled to just under 1.0.
    task automatic add_unit_quat();
        real ax;
        real ay;
        real az;
        real aw;
        real len;
        ax  = real'(int'($urandom_range(0, 65534)) - 32767);
        ay  = real'(int'($urandom_range(0, 65534)) - 32767);
        az  = real'(int'($urandom_range(0, 65534)) - 32767);
        aw  = real'(int'($urandom_range(0, 65534)) - 32767);
        len = $sqrt(ax * ax + ay * ay + az * az + aw * aw);
        if (len < 1.0) len = 1.0;
        add_quat($rtoi(ax / len * 16383.0), $rtoi(ay / len * 16383.0),
                 $rtoi(az / len * 16383.0), $rtoi(aw / len * 16383.0));
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // Stimulus and end of run.
    initial begin
        // Identity and the all-zero quaternion both point straight ahead.
        add_quat(0, 0, 0, 16384);
        add_quat(0, 0, 0, 0);
        // Sine and cosine parts both zero give a heading of zero.
        add_quat(0, 8192, 8192, 0);
        add_quat(100, 8192, 8192, -100);
        // Negative cosine part with a zero sine part turns to +pi.
        add_quat(0, 16384, 0, 0);
        add_quat(0, 0, 16384, 0);
        // Just either side of the branch cut, where the clamp to pi matters.
        add_quat(1, 16384, 0, 0);
        add_quat(-1, 16384, 0, 0);
        add_quat(0, 16384, 1, 1);
        add_quat(0, 16384, 1, -1);
        // Zero cosine part: straight left and straight right.
        add_quat(0, 8192, 8192, 16384);
        add_quat(0, 8192, 8192, -16384);
        add_quat(0, 0, 11585, 11585);
        add_quat(0, 0, -11585, 11585);
        // Field extremes.
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(32767, -32768, 32767, -32768);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(0, -32768, 0, 0);
        add_quat(0, 0, -32768, 32767);
        add_quat(32767, 32767, 0, 0);
        add_quat(-32768, 32767, 0, 0);
        add_quat(1, -1, 1, -1);

        // Random part: unit quaternions as a real sensor would report them,
        // raw bit patterns over the whole range, and tiny values near zero.
        for (int i = 0; i < N_RANDOM; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                add_unit_quat();
            end else if (r < 85) begin
                add_quat(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                         int'($signed(16'($urandom))), int'($signed(16'($urandom))));
            end else begin
                add_quat($urandom_range(0, 128) - 64, $urandom_range(0, 128) - 64,
                         $urandom_range(0, 128) - 64, $urandom_range(0, 128) - 64);
            end
        end
        n_total = quat_queue.size();

        wait (n_checked == n_total);
        repeat (DRAIN) @(posedge aclk);
        if (n_errors == 0 && heading_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Input driver. A new quaternion is put up only when the channel is free:
    // nothing is offered, or the offered one transfers at this edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                heading_t h;
                h.q.x = s_quat_x;
                h.q.y = s_quat_y;
                h.q.z = s_quat_z;
                h.q.w = s_quat_w;
                h.yaw = heading_of(h.q);
                heading_queue.push_back(h);
            end
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (quat_queue.size() > 0) begin
                next_quat = quat_queue.pop_front();
                s_quat_x  <= next_quat.x;
                s_quat_y  <= next_quat.y;
                s_quat_z  <= next_quat.z;
                s_quat_w  <= next_quat.w;
                s_valid   <= 1'b1;
                // One window of items goes in without any gaps at all.
                send_gap  <= (n_offered >= 300 && n_offered < 500) ? 0 : pick_gap();
                n_offered++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here on its own. The sender keeps
    // offering meanwhile, so the pipeline fills and s_ready must drop.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_checked >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Output ready with random stalls, except during one calm window.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            m_ready  <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_ready  <= 1'b1;
            recv_gap <= (n_checked >= 700 && n_checked < 900) ? 0 : pick_gap();
        end
    end

    // Output monitor: each transfer is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (heading_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected heading %0d", m_yaw_angle));
            end else begin
                heading_t h;
                h = heading_queue.pop_front();
                if (m_yaw_angle !== h.yaw) begin
                    report_mismatch($sformatf("q=(%0d,%0d,%0d,%0d) yaw %0d, predicted %0d",
                                              h.q.x, h.q.y, h.q.z, h.q.w,
                                              m_yaw_angle, h.yaw));
                end
            end
            n_checked++;
        end
    end

    // Watchdog for a block that stops producing results.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
